// File: design/vask_pkg.sv
package vask_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int STATE_WIDTH_DEF  = 32;
    localparam int CQ               = 20;
    localparam int CFG_DATA_WIDTH   = 23;
    localparam int CFG_IDX_WIDTH    = 3;
    localparam int COEF_WIDTH       = 24;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_G     = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_LB    = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_HB    = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ALPHA = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_RES   = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SAT   = 3'd5;

    localparam logic [20:0] G_RESET     = 21'd69846;
    localparam logic [21:0] LB_RESET    = 22'd913543;
    localparam logic [20:0] HB_RESET    = 21'h1110D1; // -978735
    localparam logic [21:0] ALPHA_RESET = 22'd1118087;
    localparam logic [21:0] RES_RESET   = 22'd1048576;
    localparam logic [21:0] RES_MIN     = 22'd210;

    // datapath micro-operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,     // acc <= sext(sample)
        OP_SUB_A,    // t <= sat(acc - state a)
        OP_MUL,      // acc (or s with keep) <= mulc(t, acc or a state, coef)
        OP_FIN1,     // y1 and state update of section one
        OP_FIN2,     // y and second state
        OP_FIN3,     // highpass state
        OP_ADD_S,    // acc <= sat(y1 + s)
        OP_CLIP,     // soft clip (multi-cycle)
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        SRC_ACC, SRC_T, SRC_S1, SRC_S2, SRC_SH
    } src_t;

    typedef enum logic [2:0] {
        CO_G, CO_LB, CO_HB, CO_ALPHA, CO_RES, CO_SAT
    } coef_sel_t;

    typedef struct packed {
        op_t       op;
        src_t      src;
        coef_sel_t coef;
        logic      keep;   // mul result to s register instead of acc
        logic      add_s;  // add mul result to s
    } dp_cmd_t;

    typedef struct packed {
        logic clip_done;
    } dp_status_t;

endpackage

// File: design/vask_if.sv
interface vask_if #(parameter int WIDTH = 24);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/va_sallen_key_lowpass_core.sv
// resonant two-pole lowpass, one signed sample in and one filtered sample out per item.
// a controller steps a datapath with one shared multiplier through the three one-pole
// sections; with saturation_gain nonzero the soft clip adds the states S_MSAT, S_WSAT,
// S_CLIP and S_WCLIP for the square, the setup and the 48-step shift-subtract divider
// of the rational tanh. the next item is taken at the earliest in the cycle the result
// is claimed. coefficients are to be written on the cfg port only while idle; the block
// itself does not enforce this.
module va_sallen_key_lowpass_core #(
    parameter int SAMPLE_WIDTH = vask_pkg::SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH  = vask_pkg::STATE_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    vask_if.sink                                  in_ch,
    vask_if.source                                out_ch,
    input  logic                                  cfg_we,
    input  logic [vask_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx,
    input  logic [vask_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
    import vask_pkg::*;

    logic [20:0] g_reg, hb_reg;
    logic [21:0] lb_reg, alpha_reg, res_reg;
    logic [22:0] sat_reg;

    // coefficient registers, resonance clamps at the low end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg     <= G_RESET;
            lb_reg    <= LB_RESET;
            hb_reg    <= HB_RESET;
            alpha_reg <= ALPHA_RESET;
            res_reg   <= RES_RESET;
            sat_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_G:     g_reg     <= cfg_data[20:0];
                REG_LB:    lb_reg    <= cfg_data[21:0];
                REG_HB:    hb_reg    <= cfg_data[20:0];
                REG_ALPHA: alpha_reg <= cfg_data[21:0];
                REG_RES:   res_reg   <= (cfg_data[21:0] < RES_MIN) ? RES_MIN : cfg_data[21:0];
                REG_SAT:   sat_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    dp_cmd_t    cmd;
    dp_status_t status;

    vask_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sat_on    (sat_reg != '0),
        .status    (status),
        .cmd       (cmd)
    );

    vask_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STATE_WIDTH  (STATE_WIDTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .sample (in_ch.data),
        .g      (g_reg),
        .lb     (lb_reg),
        .hb     (hb_reg),
        .alpha  (alpha_reg),
        .res    (res_reg),
        .satg   (sat_reg),
        .result (out_ch.data)
    );

    // no new item while the previous result still waits unclaimed
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |-> (!out_ch.valid || out_ch.ready))
        else $error("item accepted over a pending result");

    // resonance never below its floor
    assert property (@(posedge clk) disable iff (!rst_n) res_reg >= RES_MIN)
        else $error("resonance below floor");

    // a result appears only after work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> !$past(in_ch.valid && in_ch.ready))
        else $error("result raised right after acceptance");

endmodule

// File: design/vask_datapath.sv
module vask_datapath #(
    parameter int SAMPLE_WIDTH = vask_pkg::SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH  = vask_pkg::STATE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vask_pkg::dp_cmd_t                   cmd,
    output vask_pkg::dp_status_t                status,
    input  logic signed [SAMPLE_WIDTH-1:0]      sample,
    input  logic [20:0]                         g,
    input  logic [21:0]                         lb,
    input  logic [20:0]                         hb,
    input  logic [21:0]                         alpha,
    input  logic [21:0]                         res,
    input  logic [22:0]                         satg,
    output logic signed [SAMPLE_WIDTH-1:0]      result
);
    import vask_pkg::*;

    localparam int SW   = STATE_WIDTH;
    localparam int FRAC = SAMPLE_WIDTH - 1;
    localparam int PW   = SW + COEF_WIDTH + 2;
    // soft clip widths: ax < 3*2^20 (22 bits), x2 < 9*2^20
    localparam int XW   = 23;
    localparam int NW   = 48;
    localparam int DW   = 28;
    localparam int QW   = 22;

    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

    function automatic logic signed [SW-1:0] sat_w(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        hi = PW'(SMAX);
        lo = PW'(SMIN);
        if (v > hi)
            return SMAX;
        else if (v < lo)
            return SMIN;
        else
            return v[SW-1:0];
    endfunction

    logic signed [SW-1:0] acc_reg, t_reg, s_reg, y1_reg;
    logic signed [SW-1:0] s1_reg, s2_reg, sh_reg;
    logic signed [SW-1:0] src_val;
    logic signed [COEF_WIDTH-1:0] coef_val;
    logic signed [PW-1:0] prod_reg;
    logic                 prod_pend_reg;
    logic                 prod_keep_reg, prod_add_reg;
    logic signed [SAMPLE_WIDTH-1:0] result_reg;

    // soft clip divider
    logic [NW-1:0] rem_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] q_reg;
    logic [5:0]    cnt_reg;
    logic          neg_reg, big_reg, clip_done_reg;
    logic [1:0]    clip_ph_reg;
    logic [XW-1:0] ax_reg;
    logic [2*XW-1:0] sq_reg;

    always_comb
    begin
        case (cmd.src)
            SRC_ACC: src_val = acc_reg;
            SRC_T:   src_val = t_reg;
            SRC_S1:  src_val = s1_reg;
            SRC_S2:  src_val = s2_reg;
            SRC_SH:  src_val = sh_reg;
            default: src_val = acc_reg;
        endcase
        case (cmd.coef)
            CO_G:     coef_val = COEF_WIDTH'(signed'({1'b0, g}));
            CO_LB:    coef_val = COEF_WIDTH'(signed'({1'b0, lb}));
            CO_HB:    coef_val = COEF_WIDTH'(signed'(hb));
            CO_ALPHA: coef_val = COEF_WIDTH'(signed'({1'b0, alpha}));
            CO_RES:   coef_val = COEF_WIDTH'(signed'({1'b0, res}));
            CO_SAT:   coef_val = COEF_WIDTH'(signed'({1'b0, satg}));
            default:  coef_val = '0;
        endcase
    end

    // mulc: full product then floor shift with half-up rounding equals the split form
    logic signed [PW-1:0] mul_full;
    logic signed [PW-1:0] mul_round;
    logic signed [SW-1:0] mul_res;
    assign mul_full  = PW'(src_val) * PW'(coef_val);
    assign mul_round = (prod_reg + PW'(1 << (CQ - 1))) >>> CQ;
    assign mul_res   = sat_w(mul_round);

    logic signed [PW-1:0] clip_x;
    generate
        if (FRAC >= CQ) begin : g_dn
            assign clip_x = PW'(acc_reg) >>> (FRAC - CQ);
        end else begin : g_up
            assign clip_x = PW'(acc_reg) <<< (CQ - FRAC);
        end
    endgenerate
    logic signed [PW-1:0] clip_ax;
    assign clip_ax = clip_x[PW-1] ? -clip_x : clip_x;

    logic signed [PW-1:0] r_signed;
    logic signed [PW-1:0] r_scaled;
    assign r_signed = neg_reg ? -PW'({1'b0, (big_reg ? QW'(1 << CQ) : q_reg)})
                              : PW'({1'b0, (big_reg ? QW'(1 << CQ) : q_reg)});
    generate
        if (FRAC >= CQ) begin : g_rs
            assign r_scaled = r_signed <<< (FRAC - CQ);
        end else begin : g_rd
            assign r_scaled = r_signed >>> (CQ - FRAC);
        end
    endgenerate

    logic [NW:0] trial;
    assign trial = {rem_reg[NW-2:0], num_reg[NW-1]} - (NW+1)'(den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            sh_reg        <= '0;
            prod_pend_reg <= 1'b0;
            clip_done_reg <= 1'b0;
            clip_ph_reg   <= '0;
        end
        else
        begin
            clip_done_reg <= (clip_ph_reg == 2'd3) && (cnt_reg == 6'd1);
            if (cmd.op == OP_MUL)
            begin
                prod_reg      <= mul_full;
                prod_pend_reg <= 1'b1;
                prod_keep_reg <= cmd.keep;
                prod_add_reg  <= cmd.add_s;
            end
            else if (prod_pend_reg)
            begin
                prod_pend_reg <= 1'b0;
                if (prod_keep_reg)
                    s_reg <= prod_add_reg ? sat_w(PW'(s_reg) + PW'(mul_res)) : mul_res;
                else
                    acc_reg <= mul_res;
            end
            case (cmd.op)
                OP_LOAD:  acc_reg <= SW'(sample);
                OP_SUB_A:
                begin
                    case (cmd.src)
                        SRC_S1:  t_reg <= sat_w(PW'(acc_reg) - PW'(s1_reg));
                        SRC_S2:  t_reg <= sat_w(PW'(acc_reg) - PW'(s2_reg));
                        default: t_reg <= sat_w(PW'(acc_reg) - PW'(sh_reg));
                    endcase
                end
                OP_FIN1:
                begin
                    y1_reg <= sat_w(PW'(acc_reg) + PW'(s1_reg));
                    s1_reg <= sat_w(PW'(sat_w(PW'(acc_reg) + PW'(s1_reg))) + PW'(acc_reg));
                end
                OP_FIN2:
                begin
                    t_reg  <= sat_w(PW'(acc_reg) + PW'(s2_reg));
                    acc_reg <= sat_w(PW'(acc_reg) + PW'(s2_reg));
                    s2_reg <= sat_w(PW'(sat_w(PW'(acc_reg) + PW'(s2_reg))) + PW'(acc_reg));
                    if (sat_w(PW'(acc_reg) + PW'(s2_reg)) > SW'(signed'({1'b0, {FRAC{1'b1}}})))
                        result_reg <= {1'b0, {FRAC{1'b1}}};
                    else if (sat_w(PW'(acc_reg) + PW'(s2_reg)) < -SW'(signed'({1'b0, {FRAC{1'b1}}})) - SW'(1))
                        result_reg <= {1'b1, {FRAC{1'b0}}};
                    else
                        result_reg <= SAMPLE_WIDTH'(sat_w(PW'(acc_reg) + PW'(s2_reg)));
                end
                OP_FIN3:
                    sh_reg <= sat_w(PW'(sh_reg) + PW'(acc_reg) + PW'(acc_reg));
                OP_ADD_S:
                    acc_reg <= sat_w(PW'(y1_reg) + PW'(s_reg));
                OP_CLIP:
                begin
                    neg_reg     <= clip_x[PW-1];
                    big_reg     <= clip_ax >= PW'(3 << CQ);
                    ax_reg      <= XW'(clip_ax);
                    clip_ph_reg <= 2'd1;
                end
                default: ;
            endcase
            // soft clip sequence: square, numerator/denominator, divide
            if (clip_ph_reg == 2'd1)
            begin
                sq_reg      <= ax_reg * ax_reg;
                clip_ph_reg <= 2'd2;
            end
            else if (clip_ph_reg == 2'd2)
            begin
                num_reg      <= NW'(ax_reg) * NW'((27 << CQ) + (sq_reg >> CQ));
                den_reg      <= DW'(27 << CQ) + DW'(9 * (sq_reg >> CQ));
                rem_reg      <= '0;
                q_reg        <= '0;
                cnt_reg      <= 6'(NW);
                clip_ph_reg  <= 2'd3;
            end
            else if (clip_ph_reg == 2'd3)
            begin
                num_reg <= {num_reg[NW-2:0], 1'b0};
                if (!trial[NW])
                begin
                    rem_reg <= trial[NW-1:0];
                    q_reg   <= {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[NW-2:0], num_reg[NW-1]};
                    q_reg   <= {q_reg[QW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    clip_ph_reg  <= 2'd0;
                end
            end
            if (clip_done_reg)
                acc_reg <= sat_w(r_scaled);
        end
    end

    assign status.clip_done = clip_done_reg;
    assign result = result_reg;

endmodule

// File: design/vask_ctrl.sv
module vask_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  sat_on,
    input  vask_pkg::dp_status_t  status,
    output vask_pkg::dp_cmd_t     cmd
);
    import vask_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_SUB1, S_MUL1, S_W1, S_FIN1,
        S_MHB, S_WHB, S_MLB, S_WLB, S_ADDS, S_MALP, S_WALP,
        S_MSAT, S_WSAT, S_CLIP, S_WCLIP,
        S_SUB2, S_MUL2, S_W2, S_FIN2,
        S_MRES, S_WRES, S_SUB3, S_MUL3, S_W3, S_FIN3
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:  if (in_valid && in_ready) state_reg <= S_SUB1;
                S_SUB1:  state_reg <= S_MUL1;
                S_MUL1:  state_reg <= S_W1;
                S_W1:    state_reg <= S_FIN1;
                S_FIN1:  state_reg <= S_MHB;
                S_MHB:   state_reg <= S_WHB;
                S_WHB:   state_reg <= S_MLB;
                S_MLB:   state_reg <= S_WLB;
                S_WLB:   state_reg <= S_ADDS;
                S_ADDS:  state_reg <= S_MALP;
                S_MALP:  state_reg <= S_WALP;
                S_WALP:  state_reg <= sat_on ? S_MSAT : S_SUB2;
                S_MSAT:  state_reg <= S_WSAT;
                S_WSAT:  state_reg <= S_CLIP;
                S_CLIP:  state_reg <= S_WCLIP;
                S_WCLIP: if (status.clip_done) state_reg <= S_SUB2;
                S_SUB2:  state_reg <= S_MUL2;
                S_MUL2:  state_reg <= S_W2;
                S_W2:    state_reg <= S_FIN2;
                S_FIN2:  state_reg <= S_MRES;
                S_MRES:  state_reg <= S_WRES;
                S_WRES:  state_reg <= S_SUB3;
                S_SUB3:  state_reg <= S_MUL3;
                S_MUL3:  state_reg <= S_W3;
                S_W3:    state_reg <= S_FIN3;
                S_FIN3:
                begin
                    state_reg     <= S_IDLE;
                    out_valid_reg <= 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // next item may enter while the result waits, as long as the result is taken in the same cycle
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '{op: OP_NONE, src: SRC_ACC, coef: CO_G, keep: 1'b0, add_s: 1'b0};
        case (state_reg)
            S_IDLE:  if (in_valid && in_ready) cmd.op = OP_LOAD;
            S_SUB1:  begin cmd.op = OP_SUB_A; cmd.src = SRC_S1; end
            S_MUL1:  begin cmd.op = OP_MUL; cmd.src = SRC_T; cmd.coef = CO_G; end
            S_FIN1:  cmd.op = OP_FIN1;
            S_MHB:   begin cmd.op = OP_MUL; cmd.src = SRC_SH; cmd.coef = CO_HB;
                           cmd.keep = 1'b1; end
            S_MLB:   begin cmd.op = OP_MUL; cmd.src = SRC_S2; cmd.coef = CO_LB;
                           cmd.keep = 1'b1; cmd.add_s = 1'b1; end
            S_ADDS:  cmd.op = OP_ADD_S;
            S_MALP:  begin cmd.op = OP_MUL; cmd.src = SRC_ACC; cmd.coef = CO_ALPHA; end
            S_MSAT:  begin cmd.op = OP_MUL; cmd.src = SRC_ACC; cmd.coef = CO_SAT; end
            S_CLIP:  cmd.op = OP_CLIP;
            S_SUB2:  begin cmd.op = OP_SUB_A; cmd.src = SRC_S2; end
            S_MUL2:  begin cmd.op = OP_MUL; cmd.src = SRC_T; cmd.coef = CO_G; end
            S_FIN2:  cmd.op = OP_FIN2;
            S_MRES:  begin cmd.op = OP_MUL; cmd.src = SRC_ACC; cmd.coef = CO_RES; end
            S_SUB3:  begin cmd.op = OP_SUB_A; cmd.src = SRC_SH; end
            S_MUL3:  begin cmd.op = OP_MUL; cmd.src = SRC_T; cmd.coef = CO_G; end
            S_FIN3:  cmd.op = OP_FIN3;
            default: ;
        endcase
    end

endmodule
